[rtl/scsa_pkg.sv]
// types, command and status codes and class constants for the slot allocator
// no dependencies
package scsa_pkg;

  localparam int unsigned NUM_CLASSES = 4;
  localparam int unsigned MAX_SLOTS   = 16;

  typedef enum logic [1:0] {
    CMD_ALLOC     = 2'd0,
    CMD_FREE      = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_CLEAR_ALT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_POOL_ALLOC = 3'd0,
    ST_ALLOC_MISS = 3'd1,
    ST_POOL_FREE  = 3'd2,
    ST_FREE_MISS  = 3'd3,
    ST_CLEARED    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load_in;
    logic load_prod;
    logic exec;
  } ctrl_t;

  localparam logic [1:0] CLS_SMALL  = 2'd0;
  localparam logic [1:0] CLS_MEDIUM = 2'd1;
  localparam logic [1:0] CLS_LARGE  = 2'd2;
  localparam logic [1:0] CLS_XLARGE = 2'd3;

  localparam logic [23:0] CLASS_PIXELS [NUM_CLASSES] = '{
    24'(320 * 240), 24'(640 * 480), 24'(1024 * 768), 24'(1920 * 1080)
  };

  localparam logic [25:0] CLASS_BYTES [NUM_CLASSES] = '{
    26'(320 * 240 * 4), 26'(640 * 480 * 4), 26'(1024 * 768 * 4), 26'(1920 * 1080 * 4)
  };

endpackage

[rtl/scsa_req_if.sv]
// request channel of the slot allocator: valid, ready and command payload
// no dependencies
interface scsa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] width;
  logic [11:0] height;
  logic [2:0]  free_class;
  logic [3:0]  free_slot;

  modport source (output valid, cmd, width, height, free_class, free_slot, input ready);
  modport sink (input valid, cmd, width, height, free_class, free_slot, output ready);
endinterface

[rtl/scsa_rsp_if.sv]
// response channel of the slot allocator: valid, ready and result payload
// no dependencies
interface scsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  grant_class;
  logic [3:0]  grant_slot;
  logic [25:0] bytes_in_use;
  logic [31:0] hit_count;
  logic [31:0] miss_count;
  logic [31:0] free_hit_count;
  logic [31:0] free_miss_count;

  modport source (output valid, status, grant_class, grant_slot, bytes_in_use, hit_count,
                  miss_count, free_hit_count, free_miss_count, input ready);
  modport sink (input valid, status, grant_class, grant_slot, bytes_in_use, hit_count,
                miss_count, free_hit_count, free_miss_count, output ready);
endinterface

[rtl/size_class_slot_allocator.sv]
// top level of the size class slot allocator: controller plus datapath
// depends on scsa_pkg, scsa_req_if, scsa_rsp_if, scsa_ctrl, scsa_dp
//
// usage:
//   req carries one command per transfer: allocate (width x height), free
//   (class and slot) or clear statistics. rsp carries one result per request,
//   in order, with status, granted class and slot, bytes in use and the four
//   hit/miss counters as they stand after the command.
//   each request passes through three steps: a register stage for the request,
//   one for the 12x12 product, and one that scans the busy maps, updates state
//   and loads the response register. one request is in flight at a time, so
//   no new request is taken until the current one has passed its execute
//   step. rsp.valid is registered and rises after the execute step.
//   a stalled receiver holds the response register; the next request is
//   still taken and processed up to its execute step, which waits until the
//   held response has been taken.
//   synchronous reset frees every usable slot and zeroes bytes and counters;
//   the block takes a request in the first cycle after reset.
module size_class_slot_allocator
  import scsa_pkg::*;
#(
  parameter int unsigned SMALL_SLOTS  = 16,
  parameter int unsigned MEDIUM_SLOTS = 8,
  parameter int unsigned LARGE_SLOTS  = 4,
  parameter int unsigned XLARGE_SLOTS = 2
) (
  input logic       clk,
  input logic       rst,
  scsa_req_if.sink  req,
  scsa_rsp_if.source rsp
);

  ctrl_t ctrl;

  scsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctrl      (ctrl)
  );

  scsa_dp #(
    .SMALL_SLOTS  (SMALL_SLOTS),
    .MEDIUM_SLOTS (MEDIUM_SLOTS),
    .LARGE_SLOTS  (LARGE_SLOTS),
    .XLARGE_SLOTS (XLARGE_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .cmd             (req.cmd),
    .width           (req.width),
    .height          (req.height),
    .free_class      (req.free_class),
    .free_slot       (req.free_slot),
    .status          (rsp.status),
    .grant_class     (rsp.grant_class),
    .grant_slot      (rsp.grant_slot),
    .bytes_in_use    (rsp.bytes_in_use),
    .hit_count       (rsp.hit_count),
    .miss_count      (rsp.miss_count),
    .free_hit_count  (rsp.free_hit_count),
    .free_miss_count (rsp.free_miss_count)
  );

endmodule

[rtl/scsa_ctrl.sv]
// controller of the slot allocator: sequences load, multiply and execute
// and owns the response valid flag; depends on scsa_pkg
module scsa_ctrl
  import scsa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output ctrl_t ctrl
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctrl       = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load_in = 1'b1;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        ctrl.load_prod = 1'b1;
        state_next     = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid || out_ready) begin
          ctrl.exec  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (ctrl.exec) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

[rtl/scsa_dp.sv]
// datapath of the slot allocator: request registers, product, busy maps,
// counters and response registers; depends on scsa_pkg
module scsa_dp
  import scsa_pkg::*;
#(
  parameter int unsigned SMALL_SLOTS  = 16,
  parameter int unsigned MEDIUM_SLOTS = 8,
  parameter int unsigned LARGE_SLOTS  = 4,
  parameter int unsigned XLARGE_SLOTS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  input  logic [1:0]  cmd,
  input  logic [11:0] width,
  input  logic [11:0] height,
  input  logic [2:0]  free_class,
  input  logic [3:0]  free_slot,
  output logic [2:0]  status,
  output logic [1:0]  grant_class,
  output logic [3:0]  grant_slot,
  output logic [25:0] bytes_in_use,
  output logic [31:0] hit_count,
  output logic [31:0] miss_count,
  output logic [31:0] free_hit_count,
  output logic [31:0] free_miss_count
);

  localparam logic [4:0] LIMIT [NUM_CLASSES] = '{
    5'(SMALL_SLOTS), 5'(MEDIUM_SLOTS), 5'(LARGE_SLOTS), 5'(XLARGE_SLOTS)
  };

  // slots beyond a class's count sit permanently busy
  localparam logic [15:0] PAD [NUM_CLASSES] = '{
    16'(32'hFFFF << SMALL_SLOTS), 16'(32'hFFFF << MEDIUM_SLOTS),
    16'(32'hFFFF << LARGE_SLOTS), 16'(32'hFFFF << XLARGE_SLOTS)
  };

  cmd_t        cmd_q;
  logic [11:0] width_q;
  logic [11:0] height_q;
  logic [2:0]  free_class_q;
  logic [3:0]  free_slot_q;
  logic [23:0] prod;

  logic [15:0] busy [NUM_CLASSES];
  logic [15:0] busy_next [NUM_CLASSES];
  logic [25:0] used_bytes, used_bytes_next;
  logic [31:0] grant_total, grant_total_next;
  logic [31:0] miss_total, miss_total_next;
  logic [31:0] release_hits, release_hits_next;
  logic [31:0] release_misses, release_misses_next;

  logic [NUM_CLASSES-1:0] fits;
  logic [NUM_CLASSES-1:0] has_free;
  logic [3:0]             first_free [NUM_CLASSES];
  logic                   found;
  logic [1:0]             sel_class;
  logic [1:0]             fcls;
  logic                   free_ok;
  status_t                status_next;
  logic [1:0]             gcls_next;
  logic [3:0]             gslot_next;

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_q        <= cmd_t'(cmd);
      width_q      <= width;
      height_q     <= height;
      free_class_q <= free_class;
      free_slot_q  <= free_slot;
    end
    if (ctrl.load_prod) begin
      prod <= width_q * height_q;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      fits[c]       = prod <= CLASS_PIXELS[c];
      has_free[c]   = ~&busy[c];
      first_free[c] = 4'd0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
        if (!busy[c][i]) first_free[c] = 4'(i);
      end
    end
    found     = 1'b0;
    sel_class = CLS_SMALL;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (fits[c] && has_free[c]) begin
        found     = 1'b1;
        sel_class = 2'(c);
      end
    end
  end

  assign fcls    = free_class_q[1:0];
  assign free_ok = !free_class_q[2] && ({1'b0, free_slot_q} < LIMIT[fcls]);

  always_comb begin
    busy_next           = busy;
    used_bytes_next     = used_bytes;
    grant_total_next    = grant_total;
    miss_total_next     = miss_total;
    release_hits_next   = release_hits;
    release_misses_next = release_misses;
    status_next         = ST_CLEARED;
    gcls_next           = CLS_SMALL;
    gslot_next          = 4'd0;
    case (cmd_q) inside
      CMD_ALLOC: begin
        if (found) begin
          busy_next[sel_class][first_free[sel_class]] = 1'b1;
          used_bytes_next  = used_bytes + CLASS_BYTES[sel_class];
          grant_total_next = grant_total + 32'd1;
          status_next      = ST_POOL_ALLOC;
          gcls_next        = sel_class;
          gslot_next       = first_free[sel_class];
        end else begin
          miss_total_next = miss_total + 32'd1;
          status_next     = ST_ALLOC_MISS;
        end
      end
      CMD_FREE: begin
        if (free_ok) begin
          if (busy[fcls][free_slot_q]) begin
            busy_next[fcls][free_slot_q] = 1'b0;
            used_bytes_next = used_bytes - CLASS_BYTES[fcls];
          end
          release_hits_next = release_hits + 32'd1;
          status_next       = ST_POOL_FREE;
        end else begin
          release_misses_next = release_misses + 32'd1;
          status_next         = ST_FREE_MISS;
        end
      end
      CMD_CLEAR, CMD_CLEAR_ALT: begin
        grant_total_next    = '0;
        miss_total_next     = '0;
        release_hits_next   = '0;
        release_misses_next = '0;
        status_next         = ST_CLEARED;
      end
      default: status_next = ST_CLEARED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= PAD;
      used_bytes     <= '0;
      grant_total    <= '0;
      miss_total     <= '0;
      release_hits   <= '0;
      release_misses <= '0;
    end else if (ctrl.exec) begin
      busy           <= busy_next;
      used_bytes     <= used_bytes_next;
      grant_total    <= grant_total_next;
      miss_total     <= miss_total_next;
      release_hits   <= release_hits_next;
      release_misses <= release_misses_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      status          <= status_next;
      grant_class     <= gcls_next;
      grant_slot      <= gslot_next;
      bytes_in_use    <= used_bytes_next;
      hit_count       <= grant_total_next;
      miss_count      <= miss_total_next;
      free_hit_count  <= release_hits_next;
      free_miss_count <= release_misses_next;
    end
  end

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for size_class_slot_allocator: directed and random traffic
// on req and rsp; a behavioural slot and counter model checks every rsp transfer
// depends on scsa_pkg, scsa_req_if, scsa_rsp_if and the allocator rtl
module testbench;
  import scsa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_CMDS = 1500;

  localparam int unsigned CLASS_PIX [4] = '{320 * 240, 640 * 480, 1024 * 768, 1920 * 1080};
  localparam int unsigned SLOT_COUNT [4] = '{16, 8, 4, 2};
  localparam int unsigned W_LIM [5] = '{320, 640, 1024, 1920, 4095};
  localparam int unsigned H_LIM [5] = '{240, 480, 768, 1080, 4095};

  typedef struct packed {
    cmd_t        cmd;
    logic [11:0] width;
    logic [11:0] height;
    logic [2:0]  free_class;
    logic [3:0]  free_slot;
  } cmd_item_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  grant_class;
    logic [3:0]  grant_slot;
    logic [25:0] bytes_in_use;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] free_hit_count;
    logic [31:0] free_miss_count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scsa_req_if req_ch();
  scsa_rsp_if rsp_ch();

  size_class_slot_allocator dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #1 clk = ~clk;

  // allocator state as the block should hold it
  logic [15:0] slot_busy [4] = '{default: '0};
  logic [25:0] bytes_used = '0;
  logic [31:0] alloc_hit_n = '0;
  logic [31:0] alloc_miss_n = '0;
  logic [31:0] release_hit_n = '0;
  logic [31:0] release_miss_n = '0;

  cmd_item_t pending_cmds [$];
  outcome_t  outcome_q [$];

  int mismatches = 0;
  int cycle_n = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int sent_n = 0;
  int grants = 0, alloc_fails_seen = 0, frees = 0, free_misses_seen = 0, clears = 0;
  logic [25:0] peak_bytes = '0;

  function automatic outcome_t run_command(input cmd_item_t it);
    outcome_t o;
    logic [23:0] pix;
    bit found;
    o = '0;
    found = 1'b0;
    case (it.cmd)
      CMD_ALLOC: begin
        pix = it.width * it.height;
        for (int c = 0; c < 4 && !found; c++) begin
          if (pix <= CLASS_PIX[c]) begin
            for (int i = 0; i < SLOT_COUNT[c] && !found; i++) begin
              if (!slot_busy[c][i]) begin
                slot_busy[c][i] = 1'b1;
                bytes_used = bytes_used + 26'(CLASS_PIX[c] * 4);
                alloc_hit_n = alloc_hit_n + 1;
                o.grant_class = 2'(c);
                o.grant_slot = 4'(i);
                found = 1'b1;
              end
            end
          end
        end
        if (found) begin
          o.status = ST_POOL_ALLOC;
        end else begin
          alloc_miss_n = alloc_miss_n + 1;
          o.status = ST_ALLOC_MISS;
        end
      end
      CMD_FREE: begin
        if (it.free_class < 4 && it.free_slot < SLOT_COUNT[it.free_class[1:0]]) begin
          if (slot_busy[it.free_class[1:0]][it.free_slot]) begin
            slot_busy[it.free_class[1:0]][it.free_slot] = 1'b0;
            bytes_used = bytes_used - 26'(CLASS_PIX[it.free_class[1:0]] * 4);
          end
          release_hit_n = release_hit_n + 1;
          o.status = ST_POOL_FREE;
        end else begin
          release_miss_n = release_miss_n + 1;
          o.status = ST_FREE_MISS;
        end
      end
      default: begin
        alloc_hit_n = '0;
        alloc_miss_n = '0;
        release_hit_n = '0;
        release_miss_n = '0;
        o.status = ST_CLEARED;
      end
    endcase
    o.bytes_in_use = bytes_used;
    o.hit_count = alloc_hit_n;
    o.miss_count = alloc_miss_n;
    o.free_hit_count = release_hit_n;
    o.free_miss_count = release_miss_n;
    return o;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic push_cmd(input cmd_t cmd, input int w, input int h, input int fc, input int fs);
    cmd_item_t it;
    it.cmd = cmd;
    it.width = 12'(w);
    it.height = 12'(h);
    it.free_class = 3'(fc);
    it.free_slot = 4'(fs);
    pending_cmds.push_back(it);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // req driver
  always @(posedge clk) begin : drive_req
    cmd_item_t acc;
    cmd_item_t nxt;
    bit take;
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      take = req_ch.valid && req_ch.ready;
      if (take) begin
        acc.cmd = cmd_t'(req_ch.cmd);
        acc.width = req_ch.width;
        acc.height = req_ch.height;
        acc.free_class = req_ch.free_class;
        acc.free_slot = req_ch.free_slot;
        outcome_q.push_back(run_command(acc));
        sent_n++;
      end
      if (req_ch.valid && !take) begin
        req_ch.valid <= 1'b1;
      end else if (gap_left != 0) begin
        req_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.cmd <= nxt.cmd;
        req_ch.width <= nxt.width;
        req_ch.height <= nxt.height;
        req_ch.free_class <= nxt.free_class;
        req_ch.free_slot <= nxt.free_slot;
        if ($urandom_range(0, 79) == 0) send_calm = ~send_calm;
        if (!send_calm && $urandom_range(0, 99) < 40) gap_left <= gap_len();
        else gap_left <= 0;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // rsp monitor and stall generator
  always @(posedge clk) begin : watch_rsp
    outcome_t got;
    outcome_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = status_t'(rsp_ch.status);
        got.grant_class = rsp_ch.grant_class;
        got.grant_slot = rsp_ch.grant_slot;
        got.bytes_in_use = rsp_ch.bytes_in_use;
        got.hit_count = rsp_ch.hit_count;
        got.miss_count = rsp_ch.miss_count;
        got.free_hit_count = rsp_ch.free_hit_count;
        got.free_miss_count = rsp_ch.free_miss_count;
        if (outcome_q.size() == 0) begin
          $display("%0t: unrequested transfer, expected none, got status %0d", $time,
                   rsp_ch.status);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("grant_class", 32'(want.grant_class), 32'(got.grant_class));
          check_field("grant_slot", 32'(want.grant_slot), 32'(got.grant_slot));
          check_field("bytes_in_use", 32'(want.bytes_in_use), 32'(got.bytes_in_use));
          check_field("hit_count", want.hit_count, got.hit_count);
          check_field("miss_count", want.miss_count, got.miss_count);
          check_field("free_hit_count", want.free_hit_count, got.free_hit_count);
          check_field("free_miss_count", want.free_miss_count, got.free_miss_count);
        end
        case (got.status)
          ST_POOL_ALLOC: grants++;
          ST_ALLOC_MISS: alloc_fails_seen++;
          ST_POOL_FREE:  frees++;
          ST_FREE_MISS:  free_misses_seen++;
          default:       clears++;
        endcase
        if (got.bytes_in_use > peak_bytes) peak_bytes = got.bytes_in_use;
        if ($urandom_range(0, 59) == 0) recv_calm = ~recv_calm;
      end
      if (stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!recv_calm && $urandom_range(0, 99) < 25) stall_left <= gap_len();
      end
    end
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("size_class_slot_allocator regression: fail");
      $finish;
    end
  end

  initial begin
    int phase_left;
    int alloc_bias;
    int k;
    int c;
    int fc;
    int total_cmds;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_ALLOC;
    req_ch.width = '0;
    req_ch.height = '0;
    req_ch.free_class = '0;
    req_ch.free_slot = '0;
    rsp_ch.ready = 1'b0;

    // class boundaries, pool exhaustion, oversize, bad and idle frees, both clear codes
    push_cmd(CMD_ALLOC, 0, 0, 0, 0);
    push_cmd(CMD_ALLOC, 320, 240, 7, 15);
    push_cmd(CMD_ALLOC, 321, 240, 0, 0);
    push_cmd(CMD_ALLOC, 640, 480, 0, 0);
    push_cmd(CMD_ALLOC, 1024, 768, 0, 0);
    push_cmd(CMD_ALLOC, 1920, 1080, 0, 0);
    push_cmd(CMD_ALLOC, 1920, 1080, 0, 0);
    push_cmd(CMD_ALLOC, 1920, 1080, 0, 0);
    push_cmd(CMD_ALLOC, 1921, 1080, 0, 0);
    push_cmd(CMD_ALLOC, 4095, 4095, 0, 0);
    push_cmd(CMD_ALLOC, 1, 4095, 0, 0);
    push_cmd(CMD_FREE, 4095, 4095, CLS_XLARGE, 1);
    push_cmd(CMD_FREE, 0, 0, CLS_XLARGE, 1);
    push_cmd(CMD_FREE, 0, 0, CLS_SMALL, 15);
    push_cmd(CMD_FREE, 0, 0, 4, 0);
    push_cmd(CMD_FREE, 0, 0, 7, 15);
    push_cmd(CMD_FREE, 0, 0, CLS_XLARGE, 2);
    push_cmd(CMD_FREE, 0, 0, CLS_LARGE, 4);
    push_cmd(CMD_FREE, 0, 0, CLS_MEDIUM, 8);
    push_cmd(CMD_CLEAR, 0, 0, 0, 0);
    push_cmd(CMD_ALLOC, 2048, 2048, 0, 0);
    push_cmd(CMD_CLEAR_ALT, 4095, 4095, 7, 15);
    push_cmd(CMD_FREE, 0, 0, CLS_SMALL, 0);
    push_cmd(CMD_ALLOC, 0, 4095, 0, 0);

    // phases that lean toward filling or draining the pool
    phase_left = 0;
    alloc_bias = 50;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        alloc_bias = $urandom_range(10, 90);
      end
      phase_left--;
      if ($urandom_range(0, 99) < 3) begin
        push_cmd($urandom_range(0, 1) ? CMD_CLEAR : CMD_CLEAR_ALT, $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 7), $urandom_range(0, 15));
      end else if ($urandom_range(0, 99) < alloc_bias) begin
        k = $urandom_range(0, 5);
        if (k < 5) begin
          push_cmd(CMD_ALLOC, $urandom_range(0, W_LIM[k]), $urandom_range(0, H_LIM[k]),
                   $urandom_range(0, 7), $urandom_range(0, 15));
        end else begin
          c = $urandom_range(0, 3);
          push_cmd(CMD_ALLOC, W_LIM[c], H_LIM[c] + $urandom_range(0, 1),
                   $urandom_range(0, 7), $urandom_range(0, 15));
        end
      end else if ($urandom_range(0, 9) < 8) begin
        fc = $urandom_range(0, 3);
        push_cmd(CMD_FREE, $urandom_range(0, 4095), $urandom_range(0, 4095), fc,
                 $urandom_range(0, SLOT_COUNT[fc] - 1));
      end else begin
        push_cmd(CMD_FREE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 7), $urandom_range(0, 15));
      end
    end
    total_cmds = pending_cmds.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (sent_n < total_cmds || outcome_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d commands: %0d grants, %0d alloc misses, %0d frees, %0d free misses, %0d clears",
             sent_n, grants, alloc_fails_seen, frees, free_misses_seen, clears);
    $display("peak pool bytes in use %0d, %0d mismatches", peak_bytes, mismatches);
    if (mismatches == 0) begin
      $display("size_class_slot_allocator regression: pass");
    end else begin
      $display("size_class_slot_allocator regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/scsa_pkg.sv
rtl/scsa_req_if.sv
rtl/scsa_rsp_if.sv
rtl/scsa_ctrl.sv
rtl/scsa_dp.sv
rtl/size_class_slot_allocator.sv
tb/sv/testbench.sv
